// ----- src/nttpm_pkg.sv -----
// Shared types and constants of the NTT polynomial multiplier.
// No dependencies; every other file of the block imports it.
`default_nettype none

package nttpm_pkg;

  localparam int MAX_LEN_DEF = 1024;
  localparam int MODULUS_DEF = 998244353;

  localparam int COEF_W = 30;
  localparam int VAL_W  = 31;
  localparam int OP_W   = 2;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [COEF_W-1:0] GEN_RESET = COEF_W'(3);
  localparam logic [APB_AW-1:0] REG_GENERATOR = APB_AW'(0);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_A = 2'd0,
    OP_PUSH_B = 2'd1,
    OP_POP    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic             start;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } mm_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [VAL_W-1:0] p;
  } mm_rsp_t;

endpackage

`default_nettype wire

// ----- src/nttpm_cmd_if.sv -----
// Command channel of the NTT polynomial multiplier: valid, ready and one beat.
// Depends on nttpm_pkg.
`default_nettype none

interface nttpm_cmd_if;
  import nttpm_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [COEF_W-1:0] coef_in;

  modport source (output valid, output op, output coef_in, input ready);
  modport sink (input valid, input op, input coef_in, output ready);
endinterface

`default_nettype wire

// ----- src/nttpm_res_if.sv -----
// Result channel of the NTT polynomial multiplier: valid, ready and one beat.
// Depends on nttpm_pkg.
`default_nettype none

interface nttpm_res_if;
  import nttpm_pkg::*;

  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] coef_out;
  logic              last;

  modport source (output valid, output coef_out, output last, input ready);
  modport sink (input valid, input coef_out, input last, output ready);
endinterface

`default_nettype wire

// ----- src/ntt_polynomial_multiplier.sv -----
// Top level of the NTT polynomial multiplier: sequencer, coefficient memories, APB register.
// Depends on nttpm_pkg, nttpm_cmd_if, nttpm_res_if and nttpm_mulmod.
// A push of a coefficient below the modulus is written directly; a larger one is first reduced
// through the multiplier. A pop that finds the product computed reads it out through S_POP_A
// and S_POP_B. The first pop of a job computes the product: every modular multiply goes through
// one bit-serial multiplier, so the job runs a clear pass over n entries, three transforms of
// (n/2)log2(n) butterflies with two multiplies each, 2n multiplies for the pointwise product and
// the scaling, and modular exponentiations of up to 62 multiplies each: one per stage of each
// transform and three more. The memories need no clearing pass after reset.
`default_nettype none

module ntt_polynomial_multiplier #(
  parameter int MAX_LEN = nttpm_pkg::MAX_LEN_DEF,
  parameter int MODULUS = nttpm_pkg::MODULUS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [nttpm_pkg::APB_AW-1:0] paddr,
  input  logic [nttpm_pkg::APB_DW-1:0] pwdata,
  output logic [nttpm_pkg::APB_DW-1:0] prdata,
  output logic                         pready,
  nttpm_cmd_if.sink                    cmd,
  nttpm_res_if.source                  res
);
  import nttpm_pkg::*;

  localparam int ND = 2 ** $clog2(2 * MAX_LEN);
  localparam int AW = $clog2(ND);
  localparam int NW = AW + 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int TW = CW + 1;
  localparam int SW = $clog2(AW + 2);

  localparam logic [VAL_W-1:0] MV  = VAL_W'(MODULUS);
  localparam logic [VAL_W-1:0] MM1 = VAL_W'(MODULUS - 1);
  localparam logic [VAL_W-1:0] MM2 = VAL_W'(MODULUS - 2);
  localparam logic [VAL_W-1:0] ONE = VAL_W'(1);

  typedef enum logic [30:0] {
    S_IDLE    = 31'b1 << 0,
    S_PUSH    = 31'b1 << 1,
    S_SIZE    = 31'b1 << 2,
    S_CLR     = 31'b1 << 3,
    S_GRED    = 31'b1 << 4,
    S_ROOT    = 31'b1 << 5,
    S_BR_A    = 31'b1 << 6,
    S_BR_B    = 31'b1 << 7,
    S_BR_C    = 31'b1 << 8,
    S_BR_D    = 31'b1 << 9,
    S_STW     = 31'b1 << 10,
    S_BF_INIT = 31'b1 << 11,
    S_BF_A    = 31'b1 << 12,
    S_BF_B    = 31'b1 << 13,
    S_BF_C    = 31'b1 << 14,
    S_BF_D    = 31'b1 << 15,
    S_BF_E    = 31'b1 << 16,
    S_PM_A    = 31'b1 << 17,
    S_PM_B    = 31'b1 << 18,
    S_PM_C    = 31'b1 << 19,
    S_INV     = 31'b1 << 20,
    S_NRED    = 31'b1 << 21,
    S_NSC     = 31'b1 << 22,
    S_SC_A    = 31'b1 << 23,
    S_SC_B    = 31'b1 << 24,
    S_SC_C    = 31'b1 << 25,
    S_POP_A   = 31'b1 << 26,
    S_POP_B   = 31'b1 << 27,
    S_PW_TEST = 31'b1 << 28,
    S_PW_M1   = 31'b1 << 29,
    S_PW_M2   = 31'b1 << 30
  } state_t;

  typedef enum logic [1:0] {
    T_FA  = 2'd0,
    T_FB  = 2'd1,
    T_INV = 2'd2
  } tsel_t;

  state_t            state;
  state_t            pw_ret;
  tsel_t             tsel;
  op_t               op_q;
  logic [NW-1:0]     i;
  logic [NW-1:0]     n;
  logic [NW-1:0]     st;
  logic [NW-1:0]     j;
  logic [SW-1:0]     s;
  logic [SW-1:0]     lg;
  logic [CW-1:0]     count_a;
  logic [CW-1:0]     count_b;
  logic [NW-1:0]     read_index;
  logic              computed;
  logic [COEF_W-1:0] generator;
  logic [VAL_W-1:0]  root;
  logic [VAL_W-1:0]  rcur;
  logic [VAL_W-1:0]  w;
  logic [VAL_W-1:0]  r;
  logic [VAL_W-1:0]  tu;
  logic [VAL_W-1:0]  xq;
  logic [VAL_W-1:0]  ninv;
  logic [VAL_W-1:0]  pw_base;
  logic [VAL_W-1:0]  pw_exp;
  logic [VAL_W-1:0]  pw_res;
  logic              out_valid;
  logic [COEF_W-1:0] coef_q;
  logic              last_q;

  logic [VAL_W-1:0] mem_a [ND];
  logic [VAL_W-1:0] mem_b [ND];
  logic             a_we;
  logic             b_we;
  logic [AW-1:0]    a_wa;
  logic [AW-1:0]    b_wa;
  logic [VAL_W-1:0] a_wd;
  logic [VAL_W-1:0] b_wd;
  logic [AW-1:0]    a_ra;
  logic [AW-1:0]    b_ra;
  logic [VAL_W-1:0] a_rd;
  logic [VAL_W-1:0] b_rd;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  logic              cur_b;
  logic [VAL_W-1:0]  cur_rd;
  logic [TW-1:0]     total;
  logic [NW-1:0]     total_n;
  logic              fin;
  logic              cmd_fire;
  logic [VAL_W-1:0]  coef_ext;
  logic              coef_ok;
  logic [AW-1:0]     rev_i;
  logic [NW-1:0]     y;
  logic [NW-1:0]     half;
  logic [NW-1:0]     len;
  logic [NW-1:0]     lo_idx;
  logic [NW-1:0]     hi_idx;
  logic [VAL_W:0]    sum;
  logic [VAL_W-1:0]  add_r;
  logic [VAL_W:0]    dif;
  logic [VAL_W-1:0]  sub_r;
  logic              gen_wr;

  nttpm_mulmod #(
    .MODULUS (MODULUS)
  ) u_mulmod (
    .clk (clk),
    .rst (rst),
    .req (mm_req),
    .rsp (mm_rsp)
  );

  for (genvar k = 0; k < AW; k++) begin : g_rev
    assign rev_i[k] = i[AW-1-k];
  end

  assign cur_b    = (tsel == T_FB);
  assign cur_rd   = cur_b ? b_rd : a_rd;
  assign total    = TW'(count_a) + TW'(count_b);
  assign total_n  = NW'(total);
  assign fin      = (read_index + NW'(1)) >= (total_n - NW'(1));
  assign cmd_fire = cmd.valid && cmd.ready;
  assign coef_ext = VAL_W'(cmd.coef_in);
  assign coef_ok  = coef_ext < MV;
  assign y        = NW'(rev_i) >> (SW'(AW) - lg);
  assign half     = NW'(1) << (s - SW'(1));
  assign len      = NW'(1) << s;
  assign lo_idx   = st + j;
  assign hi_idx   = st + j + half;
  assign sum      = {1'b0, cur_rd} + {1'b0, mm_rsp.p};
  assign add_r    = (sum >= {1'b0, MV}) ? VAL_W'(sum - {1'b0, MV}) : sum[VAL_W-1:0];
  assign dif      = (tu >= xq) ? {1'b0, tu - xq} : ({1'b0, tu} + {1'b0, MV} - {1'b0, xq});
  assign sub_r    = dif[VAL_W-1:0];
  assign gen_wr   = psel && penable && pwrite && (paddr == REG_GENERATOR);

  assign cmd.ready    = (state == S_IDLE) && !out_valid;
  assign res.valid    = out_valid;
  assign res.coef_out = coef_q;
  assign res.last     = last_q;
  assign pready       = 1'b1;
  assign prdata       = APB_DW'(generator);

  always_ff @(posedge clk) begin
    if (a_we) begin
      mem_a[a_wa] <= a_wd;
    end
    a_rd <= mem_a[a_ra];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      mem_b[b_wa] <= b_wd;
    end
    b_rd <= mem_b[b_ra];
  end

  always_comb begin
    a_we   = 1'b0;
    b_we   = 1'b0;
    a_wa   = i[AW-1:0];
    b_wa   = i[AW-1:0];
    a_wd   = '0;
    b_wd   = '0;
    a_ra   = i[AW-1:0];
    b_ra   = i[AW-1:0];
    mm_req = '{start: 1'b0, a: pw_base, b: pw_base};
    unique case (state)
      S_IDLE: begin
        if (cmd_fire && !computed && coef_ok) begin
          if (op_t'(cmd.op) == OP_PUSH_A && count_a < CW'(MAX_LEN)) begin
            a_we = 1'b1;
            a_wa = AW'(count_a);
            a_wd = coef_ext;
          end
          if (op_t'(cmd.op) == OP_PUSH_B && count_b < CW'(MAX_LEN)) begin
            b_we = 1'b1;
            b_wa = AW'(count_b);
            b_wd = coef_ext;
          end
        end
        if (cmd_fire && !computed && !coef_ok &&
            ((op_t'(cmd.op) == OP_PUSH_A && count_a < CW'(MAX_LEN)) ||
             (op_t'(cmd.op) == OP_PUSH_B && count_b < CW'(MAX_LEN)))) begin
          mm_req = '{start: 1'b1, a: coef_ext, b: ONE};
        end
      end
      S_PUSH: begin
        if (mm_rsp.done) begin
          a_we = (op_q == OP_PUSH_A);
          b_we = (op_q == OP_PUSH_B);
          a_wa = AW'(count_a);
          b_wa = AW'(count_b);
          a_wd = mm_rsp.p;
          b_wd = mm_rsp.p;
        end
      end
      S_CLR: begin
        if (i == n) begin
          mm_req = '{start: 1'b1, a: VAL_W'(generator), b: ONE};
        end else begin
          a_we = (i >= NW'(count_a));
          b_we = (i >= NW'(count_b));
        end
      end
      S_BR_B: begin
        a_ra = y[AW-1:0];
        b_ra = y[AW-1:0];
      end
      S_BR_C: begin
        a_we = !cur_b;
        b_we = cur_b;
        a_wd = cur_rd;
        b_wd = cur_rd;
      end
      S_BR_D: begin
        a_we = !cur_b;
        b_we = cur_b;
        a_wa = y[AW-1:0];
        b_wa = y[AW-1:0];
        a_wd = tu;
        b_wd = tu;
      end
      S_STW: begin
        if (s > lg && tsel == T_INV) begin
          mm_req = '{start: 1'b1, a: VAL_W'(n), b: ONE};
        end
      end
      S_BF_A: begin
        a_ra = hi_idx[AW-1:0];
        b_ra = hi_idx[AW-1:0];
      end
      S_BF_B: begin
        a_ra   = lo_idx[AW-1:0];
        b_ra   = lo_idx[AW-1:0];
        mm_req = '{start: 1'b1, a: r, b: cur_rd};
      end
      S_BF_C: begin
        a_ra = lo_idx[AW-1:0];
        b_ra = lo_idx[AW-1:0];
        if (mm_rsp.done) begin
          a_we = !cur_b;
          b_we = cur_b;
          a_wa = lo_idx[AW-1:0];
          b_wa = lo_idx[AW-1:0];
          a_wd = add_r;
          b_wd = add_r;
        end
      end
      S_BF_D: begin
        a_we   = !cur_b;
        b_we   = cur_b;
        a_wa   = hi_idx[AW-1:0];
        b_wa   = hi_idx[AW-1:0];
        a_wd   = sub_r;
        b_wd   = sub_r;
        mm_req = '{start: 1'b1, a: r, b: w};
      end
      S_PM_B: begin
        mm_req = '{start: 1'b1, a: a_rd, b: b_rd};
      end
      S_PM_C: begin
        if (mm_rsp.done) begin
          a_we = 1'b1;
          a_wd = mm_rsp.p;
        end
      end
      S_SC_B: begin
        mm_req = '{start: 1'b1, a: ninv, b: a_rd};
      end
      S_SC_C: begin
        if (mm_rsp.done) begin
          a_we = 1'b1;
          a_wd = mm_rsp.p;
        end
      end
      S_POP_A: begin
        a_ra = read_index[AW-1:0];
      end
      S_PW_TEST: begin
        if (pw_exp != '0) begin
          if (pw_exp[0]) begin
            mm_req = '{start: 1'b1, a: pw_res, b: pw_base};
          end else begin
            mm_req = '{start: 1'b1, a: pw_base, b: pw_base};
          end
        end
      end
      S_PW_M1: begin
        if (mm_rsp.done) begin
          mm_req = '{start: 1'b1, a: pw_base, b: pw_base};
        end
      end
      S_SIZE, S_GRED, S_ROOT, S_BR_A, S_BF_INIT, S_BF_E, S_PM_A, S_INV, S_NRED,
      S_NSC, S_SC_A, S_POP_B, S_PW_M2: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      generator <= GEN_RESET;
    end else if (gen_wr) begin
      generator <= pwdata[COEF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count_a    <= '0;
      count_b    <= '0;
      read_index <= '0;
      computed   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            op_q <= op_t'(cmd.op);
            unique case (op_t'(cmd.op))
              OP_PUSH_A: begin
                if (!computed && count_a < CW'(MAX_LEN)) begin
                  if (coef_ok) begin
                    count_a <= count_a + CW'(1);
                  end else begin
                    state <= S_PUSH;
                  end
                end
              end
              OP_PUSH_B: begin
                if (!computed && count_b < CW'(MAX_LEN)) begin
                  if (coef_ok) begin
                    count_b <= count_b + CW'(1);
                  end else begin
                    state <= S_PUSH;
                  end
                end
              end
              OP_POP: begin
                if (total <= TW'(1)) begin
                  out_valid  <= 1'b1;
                  coef_q     <= '0;
                  last_q     <= 1'b1;
                  count_a    <= '0;
                  count_b    <= '0;
                  read_index <= '0;
                  computed   <= 1'b0;
                end else if (computed) begin
                  state <= S_POP_A;
                end else begin
                  n     <= NW'(1);
                  lg    <= '0;
                  state <= S_SIZE;
                end
              end
              OP_NONE: begin
              end
              default: begin
              end
            endcase
          end
        end
        S_PUSH: begin
          if (mm_rsp.done) begin
            if (op_q == OP_PUSH_A) begin
              count_a <= count_a + CW'(1);
            end else begin
              count_b <= count_b + CW'(1);
            end
            state <= S_IDLE;
          end
        end
        S_SIZE: begin
          if (n < total_n) begin
            n  <= n << 1;
            lg <= lg + SW'(1);
          end else begin
            i     <= '0;
            state <= S_CLR;
          end
        end
        S_CLR: begin
          if (i == n) begin
            state <= S_GRED;
          end else begin
            i <= i + NW'(1);
          end
        end
        S_GRED: begin
          if (mm_rsp.done) begin
            pw_base <= mm_rsp.p;
            pw_exp  <= MM1 >> lg;
            pw_res  <= ONE;
            pw_ret  <= S_ROOT;
            state   <= S_PW_TEST;
          end
        end
        S_ROOT: begin
          root  <= pw_res;
          rcur  <= pw_res;
          tsel  <= T_FA;
          i     <= '0;
          s     <= SW'(1);
          state <= S_BR_A;
        end
        S_BR_A: begin
          if (i == n) begin
            state <= S_STW;
          end else if (y > i) begin
            state <= S_BR_B;
          end else begin
            i <= i + NW'(1);
          end
        end
        S_BR_B: begin
          tu    <= cur_rd;
          state <= S_BR_C;
        end
        S_BR_C: begin
          state <= S_BR_D;
        end
        S_BR_D: begin
          i     <= i + NW'(1);
          state <= S_BR_A;
        end
        S_STW: begin
          if (s > lg) begin
            unique case (tsel)
              T_FA: begin
                tsel  <= T_FB;
                i     <= '0;
                s     <= SW'(1);
                state <= S_BR_A;
              end
              T_FB: begin
                i     <= '0;
                state <= S_PM_A;
              end
              T_INV: begin
                state <= S_NRED;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end else begin
            pw_base <= rcur;
            pw_exp  <= VAL_W'(n) >> s;
            pw_res  <= ONE;
            pw_ret  <= S_BF_INIT;
            state   <= S_PW_TEST;
          end
        end
        S_BF_INIT: begin
          w     <= pw_res;
          st    <= '0;
          j     <= '0;
          r     <= ONE;
          state <= S_BF_A;
        end
        S_BF_A: begin
          state <= S_BF_B;
        end
        S_BF_B: begin
          state <= S_BF_C;
        end
        S_BF_C: begin
          tu <= cur_rd;
          if (mm_rsp.done) begin
            xq    <= mm_rsp.p;
            state <= S_BF_D;
          end
        end
        S_BF_D: begin
          state <= S_BF_E;
        end
        S_BF_E: begin
          if (mm_rsp.done) begin
            if (j + NW'(1) == half) begin
              r  <= ONE;
              j  <= '0;
              st <= st + len;
              if (st + len >= n) begin
                s     <= s + SW'(1);
                state <= S_STW;
              end else begin
                state <= S_BF_A;
              end
            end else begin
              r     <= mm_rsp.p;
              j     <= j + NW'(1);
              state <= S_BF_A;
            end
          end
        end
        S_PM_A: begin
          if (i == n) begin
            pw_base <= root;
            pw_exp  <= MM2;
            pw_res  <= ONE;
            pw_ret  <= S_INV;
            state   <= S_PW_TEST;
          end else begin
            state <= S_PM_B;
          end
        end
        S_PM_B: begin
          state <= S_PM_C;
        end
        S_PM_C: begin
          if (mm_rsp.done) begin
            i     <= i + NW'(1);
            state <= S_PM_A;
          end
        end
        S_INV: begin
          rcur  <= pw_res;
          tsel  <= T_INV;
          i     <= '0;
          s     <= SW'(1);
          state <= S_BR_A;
        end
        S_NRED: begin
          if (mm_rsp.done) begin
            pw_base <= mm_rsp.p;
            pw_exp  <= MM2;
            pw_res  <= ONE;
            pw_ret  <= S_NSC;
            state   <= S_PW_TEST;
          end
        end
        S_NSC: begin
          ninv  <= pw_res;
          i     <= '0;
          state <= S_SC_A;
        end
        S_SC_A: begin
          if (i == n) begin
            computed   <= 1'b1;
            read_index <= '0;
            state      <= S_POP_A;
          end else begin
            state <= S_SC_B;
          end
        end
        S_SC_B: begin
          state <= S_SC_C;
        end
        S_SC_C: begin
          if (mm_rsp.done) begin
            i     <= i + NW'(1);
            state <= S_SC_A;
          end
        end
        S_POP_A: begin
          state <= S_POP_B;
        end
        S_POP_B: begin
          out_valid <= 1'b1;
          coef_q    <= a_rd[COEF_W-1:0];
          last_q    <= fin;
          if (fin) begin
            count_a    <= '0;
            count_b    <= '0;
            read_index <= '0;
            computed   <= 1'b0;
          end else begin
            read_index <= read_index + NW'(1);
          end
          state <= S_IDLE;
        end
        S_PW_TEST: begin
          if (pw_exp == '0) begin
            state <= pw_ret;
          end else if (pw_exp[0]) begin
            state <= S_PW_M1;
          end else begin
            state <= S_PW_M2;
          end
        end
        S_PW_M1: begin
          if (mm_rsp.done) begin
            pw_res <= mm_rsp.p;
            state  <= S_PW_M2;
          end
        end
        S_PW_M2: begin
          if (mm_rsp.done) begin
            pw_base <= mm_rsp.p;
            pw_exp  <= pw_exp >> 1;
            state   <= S_PW_TEST;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    mm_req.start |-> !mm_rsp.busy)
    else $error("multiplier started while busy");

  a_computed_total: assert property (@(posedge clk) disable iff (rst)
    computed |-> (total >= TW'(2)))
    else $error("product marked computed for an empty job");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (count_a <= CW'(MAX_LEN)) && (count_b <= CW'(MAX_LEN)))
    else $error("coefficient count beyond capacity");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> (state == S_IDLE) && !out_valid)
    else $error("command accepted outside idle");

endmodule

`default_nettype wire

// ----- src/nttpm_mulmod.sv -----
// Bit-serial modular multiplier: one operand bit per cycle.
// Depends on nttpm_pkg. Operand b must be below the modulus; operand a may be any value.
`default_nettype none

module nttpm_mulmod #(
  parameter int MODULUS = nttpm_pkg::MODULUS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  nttpm_pkg::mm_req_t req,
  output nttpm_pkg::mm_rsp_t rsp
);
  import nttpm_pkg::*;

  localparam int CNT_W = $clog2(VAL_W);
  localparam logic [VAL_W+1:0] M1 = (VAL_W+2)'(MODULUS);
  localparam logic [VAL_W+1:0] M2 = M1 << 1;

  logic [VAL_W-1:0] r;
  logic [VAL_W-1:0] a_q;
  logic [VAL_W-1:0] b_q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [VAL_W+1:0] t;
  logic [VAL_W+1:0] t_red;

  always_comb begin
    t = {1'b0, r, 1'b0} + (a_q[cnt] ? {2'b00, b_q} : '0);
    if (t >= M2) begin
      t_red = t - M2;
    end else if (t >= M1) begin
      t_red = t - M1;
    end else begin
      t_red = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_q <= req.a;
      b_q <= req.b;
      r   <= '0;
      cnt <= CNT_W'(VAL_W - 1);
    end else if (busy) begin
      r   <= t_red[VAL_W-1:0];
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.p    = r;

endmodule

`default_nettype wire
